@@ src/salc_pkg.sv @@
// Shared types, constants and helpers for the set-associative LRU tag unit.
// No dependencies; salc_addr_split, salc_way_sel and the top level import this package.
package salc_pkg;

    // Field widths fixed by the stream format
    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 64;
    localparam int CNT_W       = 32;
    localparam int CMD_W       = 2;
    localparam int S_TDATA_W   = 72;   // cmd + address, padded to bytes
    localparam int OUT_FIELD_W = 1 + 7 * CNT_W;
    localparam int M_TDATA_W   = 232;  // hit + seven counters, padded to bytes

    // Configuration register widths and port shape
    localparam int IDX_CFG_W  = 4;
    localparam int OFS_CFG_W  = 6;
    localparam int WAYS_CFG_W = 4;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_ADDR_W = 2;

    // Raw set index before wrapping to storage: index_bits tops out at 15
    localparam int RAW_W = (1 << IDX_CFG_W) - 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INDEX_BITS  = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } t_cfg_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_OTHER = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [IDX_CFG_W-1:0]  index_bits;
        logic [OFS_CFG_W-1:0]  offset_bits;
        logic [WAYS_CFG_W-1:0] ways_in_use;
    } t_cfg;

    localparam logic [IDX_CFG_W-1:0]  IDX_RESET  = 4'd4;
    localparam logic [OFS_CFG_W-1:0]  OFS_RESET  = 6'd4;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

@@ src/salc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end
endmodule

@@ src/salc_addr_split.sv @@
// Cuts an address into raw set index, tag and a reciprocal quotient used to
// wrap the set index onto storage. Depends on salc_pkg.
module salc_addr_split #(
    parameter int MAX_SETS = 256
) (
    input  logic [salc_pkg::ADDR_W-1:0] i_address,
    input  salc_pkg::t_cfg              i_cfg,
    output logic [salc_pkg::RAW_W-1:0]  o_raw_set,
    output logic [salc_pkg::RAW_W-1:0]  o_quot,
    output logic [salc_pkg::TAG_W-1:0]  o_tag
);
    import salc_pkg::*;

    localparam int    SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int    RSH    = RAW_W + SET_W;
    localparam longint RECIP = (64'd1 << RSH) / MAX_SETS;
    localparam int    PROD_W = RAW_W + RSH + 1;

    logic [ADDR_W-1:0] shifted;
    logic [RAW_W-1:0]  idx_mask;
    logic [6:0]        tag_shift;
    logic [PROD_W-1:0] prod;

    always_comb begin
        shifted   = i_address >> i_cfg.offset_bits;
        idx_mask  = ~({RAW_W{1'b1}} << i_cfg.index_bits);
        o_raw_set = shifted[RAW_W-1:0] & idx_mask;
        tag_shift = 7'(i_cfg.offset_bits) + 7'(i_cfg.index_bits);
        o_tag     = (tag_shift >= 7'(ADDR_W)) ? '0 : (i_address >> tag_shift);
        // floor reciprocal: quotient is low by at most one
        prod      = PROD_W'(o_raw_set) * PROD_W'(RECIP);
        o_quot    = prod[RSH +: RAW_W];
    end
endmodule

@@ src/salc_way_sel.sv @@
// Hit detection and replacement choice over one set row read from the tag RAM.
// Depends on salc_pkg.
module salc_way_sel #(
    parameter int MAX_WAYS   = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic [MAX_WAYS*(1+salc_pkg::TAG_W+STAMP_BITS)-1:0] i_row,
    input  logic [salc_pkg::TAG_W-1:0]                         i_tag,
    input  logic [STAMP_BITS-1:0]                              i_now,
    input  logic [salc_pkg::WAYS_CFG_W-1:0]                    i_ways_in_use,
    output logic                                               o_hit,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0]   o_way
);
    import salc_pkg::*;

    localparam int ENTRY_W = 1 + TAG_W + STAMP_BITS;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LEVELS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int LEAVES  = 1 << LEVELS;

    logic [WAYS_CFG_W:0]   eff_ways;
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   valid;
    logic [MAX_WAYS-1:0]   match;
    logic [MAX_WAYS-1:0]   empty;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      empty_way;
    logic                  node_ok  [1:2*LEAVES-1];
    logic [STAMP_BITS-1:0] node_age [1:2*LEAVES-1];
    logic [WAY_W-1:0]      node_way [1:2*LEAVES-1];

    always_comb begin
        if (i_ways_in_use == '0) begin
            eff_ways = (WAYS_CFG_W+1)'(1);
        end else if ({1'b0, i_ways_in_use} > (WAYS_CFG_W+1)'(MAX_WAYS)) begin
            eff_ways = (WAYS_CFG_W+1)'(MAX_WAYS);
        end else begin
            eff_ways = {1'b0, i_ways_in_use};
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (WAYS_CFG_W+1)'(w) < eff_ways;
            valid[w]  = i_row[w*ENTRY_W + ENTRY_W - 1];
            match[w]  = in_use[w] && valid[w]
                        && (i_row[w*ENTRY_W + STAMP_BITS +: TAG_W] == i_tag);
            empty[w]  = in_use[w] && !valid[w];
        end

        // lowest matching way wins
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end
        // highest empty way is filled first
        empty_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (empty[w]) begin
                empty_way = WAY_W'(w);
            end
        end

        // oldest valid line by age tree; the left (lower) way keeps ties
        for (int l = 0; l < LEAVES; l++) begin
            if (l < MAX_WAYS) begin
                node_ok[LEAVES+l]  = in_use[l] && valid[l];
                node_age[LEAVES+l] = i_now - i_row[l*ENTRY_W +: STAMP_BITS];
            end else begin
                node_ok[LEAVES+l]  = 1'b0;
                node_age[LEAVES+l] = '0;
            end
            node_way[LEAVES+l] = WAY_W'(l);
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            if (node_ok[2*n+1] && (!node_ok[2*n] || node_age[2*n+1] > node_age[2*n])) begin
                node_ok[n]  = 1'b1;
                node_age[n] = node_age[2*n+1];
                node_way[n] = node_way[2*n+1];
            end else begin
                node_ok[n]  = node_ok[2*n];
                node_age[n] = node_age[2*n];
                node_way[n] = node_way[2*n];
            end
        end

        o_hit = |match;
        if (o_hit) begin
            o_way = hit_way;
        end else if (|empty) begin
            o_way = empty_way;
        end else begin
            o_way = node_way[1];
        end
    end
endmodule

@@ src/set_assoc_lru_cache_tags_unit.sv @@
// Top level of the set-associative LRU cache tag unit: control, counters,
// output register. Depends on salc_pkg, salc_ram, salc_addr_split, salc_way_sel.
//
//  port group      dir   payload (lowest bits first)
//  s_axis_*        in    cmd[1:0], address[65:2], zero pad to 72
//  m_axis_*        out   was_hit, then seven 32-bit counters, zero pad to 232
//  i_cfg_*         in    register index, data (index_bits/offset_bits/ways_in_use)
//
// Each item passes through address split, set wrap plus tag RAM read, then
// way compare and row write-back. The read-modify-write of one tag RAM row sets the pace.
// After reset a clearing pass over all MAX_SETS rows zeroes the valid bits;
// no item is taken until it ends. One finished result is held in the output
// register while the next item is accepted; a stalled output holds the last stage.
module set_assoc_lru_cache_tags_unit #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd[1:0], address[65:2], zeros above
    input  logic [salc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // was_hit[0], total_loads[32:1], total_stores[64:33], load_hit_count[96:65],
    // load_miss_count[128:97], store_hit_count[160:129],
    // store_miss_count[192:161], item_count[224:193], zeros above
    output logic [salc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [salc_pkg::CFG_ADDR_W-1:0]     i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import salc_pkg::*;

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENTRY_W = 1 + TAG_W + STAMP_BITS;
    localparam int ROW_W   = MAX_WAYS * ENTRY_W;
    localparam int QM_W    = RAW_W + SET_W + 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_INDEX, S_LOOK} t_state;

    t_state                r_state;
    logic [SET_W-1:0]      r_clr_row;
    t_cfg                  r_cfg;
    logic [CMD_W-1:0]      r_cmd;
    logic [RAW_W-1:0]      r_raw;
    logic [RAW_W-1:0]      r_quot;
    logic [TAG_W-1:0]      r_tag;
    logic [SET_W-1:0]      r_set;
    logic [STAMP_BITS-1:0] r_now;
    logic [CNT_W-1:0]      r_loads, r_stores, r_ld_hit, r_ld_miss;
    logic [CNT_W-1:0]      r_st_hit, r_st_miss, r_items;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    logic [CNT_W-1:0]      n_loads, n_stores, n_ld_hit, n_ld_miss;
    logic [CNT_W-1:0]      n_st_hit, n_st_miss, n_items;

    logic [RAW_W-1:0]      split_raw;
    logic [RAW_W-1:0]      split_quot;
    logic [TAG_W-1:0]      split_tag;
    logic [QM_W-1:0]       quot_mul;
    logic [RAW_W:0]        set_diff;
    logic [SET_W-1:0]      set_wrapped;

    logic [ROW_W-1:0]      ram_rd;
    logic [ROW_W-1:0]      row_new;
    logic                  ram_we;
    logic [SET_W-1:0]      ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic                  sel_hit;
    logic [WAY_W-1:0]      sel_way;

    logic                  in_fire;
    logic                  look_fire;
    logic                  is_load;
    logic                  is_store;
    logic                  hit;

    salc_addr_split #(.MAX_SETS(MAX_SETS)) u_split (
        .i_address (s_axis_tdata[CMD_W +: ADDR_W]),
        .i_cfg     (r_cfg),
        .o_raw_set (split_raw),
        .o_quot    (split_quot),
        .o_tag     (split_tag)
    );

    salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (r_state == S_INDEX),
        .i_rd_addr (set_wrapped),
        .o_rd_data (ram_rd)
    );

    salc_way_sel #(.MAX_WAYS(MAX_WAYS), .STAMP_BITS(STAMP_BITS)) u_way_sel (
        .i_row         (ram_rd),
        .i_tag         (r_tag),
        .i_now         (r_now),
        .i_ways_in_use (r_cfg.ways_in_use),
        .o_hit         (sel_hit),
        .o_way         (sel_way)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign look_fire     = (r_state == S_LOOK) && (!r_out_valid || m_axis_tready);
    assign is_load       = (r_cmd == CMD_LOAD);
    assign is_store      = (r_cmd == CMD_STORE);
    assign hit           = (is_load || is_store) && sel_hit;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // raw set modulo MAX_SETS: reciprocal quotient, then one correction step
    always_comb begin
        quot_mul    = QM_W'(r_quot) * QM_W'(MAX_SETS);
        set_diff    = {1'b0, r_raw} - quot_mul[RAW_W:0];
        if (set_diff >= (RAW_W+1)'(MAX_SETS)) begin
            set_diff = set_diff - (RAW_W+1)'(MAX_SETS);
        end
        set_wrapped = set_diff[SET_W-1:0];
    end

    always_comb begin
        row_new = ram_rd;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (sel_way == WAY_W'(w)) begin
                row_new[w*ENTRY_W +: ENTRY_W] = {1'b1, r_tag, r_now};
            end
        end
        ram_we    = (r_state == S_CLEAR) || (look_fire && (is_load || is_store));
        ram_waddr = (r_state == S_CLEAR) ? r_clr_row : r_set;
        ram_wdata = (r_state == S_CLEAR) ? '0 : row_new;
    end

    always_comb begin
        n_items   = sat_inc(r_items);
        n_loads   = is_load  ? sat_inc(r_loads)  : r_loads;
        n_stores  = is_store ? sat_inc(r_stores) : r_stores;
        n_ld_hit  = (is_load  &&  sel_hit) ? sat_inc(r_ld_hit)  : r_ld_hit;
        n_ld_miss = (is_load  && !sel_hit) ? sat_inc(r_ld_miss) : r_ld_miss;
        n_st_hit  = (is_store &&  sel_hit) ? sat_inc(r_st_hit)  : r_st_hit;
        n_st_miss = (is_store && !sel_hit) ? sat_inc(r_st_miss) : r_st_miss;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_bits  <= IDX_RESET;
            r_cfg.offset_bits <= OFS_RESET;
            r_cfg.ways_in_use <= WAYS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INDEX_BITS:  r_cfg.index_bits  <= i_cfg_data[IDX_CFG_W-1:0];
                CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data[OFS_CFG_W-1:0];
                CFG_WAYS:        r_cfg.ways_in_use <= i_cfg_data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_now       <= '0;
            r_loads     <= '0;
            r_stores    <= '0;
            r_ld_hit    <= '0;
            r_ld_miss   <= '0;
            r_st_hit    <= '0;
            r_st_miss   <= '0;
            r_items     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready && !look_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + 1'b1;
                    if (r_clr_row == SET_W'(MAX_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd   <= s_axis_tdata[CMD_W-1:0];
                        r_raw   <= split_raw;
                        r_quot  <= split_quot;
                        r_tag   <= split_tag;
                        r_state <= S_INDEX;
                    end
                end
                S_INDEX: begin
                    r_set   <= set_wrapped;
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (look_fire) begin
                        r_loads     <= n_loads;
                        r_stores    <= n_stores;
                        r_ld_hit    <= n_ld_hit;
                        r_ld_miss   <= n_ld_miss;
                        r_st_hit    <= n_st_hit;
                        r_st_miss   <= n_st_miss;
                        r_items     <= n_items;
                        r_now       <= r_now + 1'b1;
                        r_out_valid <= 1'b1;
                        r_out_data  <= {(M_TDATA_W - OUT_FIELD_W)'(0), n_items,
                                        n_st_miss, n_st_hit, n_ld_miss, n_ld_hit,
                                        n_stores, n_loads, hit};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
